@@ hdl/pair_separation_mu_histogram_unit_defines.svh @@
// assertion macros shared by the histogram unit
`ifndef PAIR_SEPARATION_MU_HISTOGRAM_UNIT_DEFINES_SVH
`define PAIR_SEPARATION_MU_HISTOGRAM_UNIT_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define PMH_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PMH_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/pmh_pkg.sv @@
`default_nettype none
package pmh_pkg;

   // fixed field widths
   localparam int BIN_W      = 48;
   localparam int WGT_W      = 16;
   localparam int RCP_W      = 24;
   localparam int FRAC_W     = 16;
   localparam int MUQ_W      = 17;
   localparam int MUB_W      = 7;
   localparam int LIM_W      = 51;
   localparam int ADDR_F_W   = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 51;
   localparam int MU_SHIFT   = 32;

   localparam logic [MUQ_W-1:0] MU_ONE  = 17'h10000;
   localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MU_BINS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SEP_SQ = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_MU_W   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SEP_W  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WGT_SCALE  = 3'd4;

   // register reset values
   localparam logic [MUB_W-1:0] RST_MU_BINS    = 7'd64;
   localparam logic [LIM_W-1:0] RST_MAX_SEP_SQ = {LIM_W{1'b1}};
   localparam logic [RCP_W-1:0] RST_INV_MU_W   = 24'h400000;
   localparam logic [RCP_W-1:0] RST_INV_SEP_W  = 24'h010000;
   localparam logic [WGT_W-1:0] RST_WGT_SCALE  = 16'h0100;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQ,
      ST_CHK,
      ST_MUL,
      ST_ROOT,
      ST_DIV,
      ST_MU,
      ST_ADR,
      ST_MRD,
      ST_MUSE,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

@@ hdl/pair_separation_mu_histogram_unit.sv @@
// Weighted s-mu pair histogram. Each add transaction carries one particle
// pair; the unit forms separation and doubled midpoint, skips pairs at or
// beyond the squared separation limit, bins separation and |mu| and adds
// weight_scale*aw*bw into the bin with saturation. An add runs the bit-serial
// square sums, the bit-serial s2*L2 product, the one-bit-per-cycle square
// root and the 17-step mu divider in that order; a skipped pair ends after
// the square sums. A read fetches one bin, a clear zeroes one. After reset
// the store is swept to zero, one bin per cycle, over all SEP_BINS*MU_BINS_MAX
// bins before the first transaction is taken. The user must write
// configuration only while idle; the block itself does not enforce this.
`default_nettype none
`include "pair_separation_mu_histogram_unit_defines.svh"
module pair_separation_mu_histogram_unit #(
   parameter int SEP_BINS    = 64,
   parameter int MU_BINS_MAX = 64,
   parameter int COORD_BITS  = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_func,
   input  logic signed [COORD_BITS-1:0]     req_ax,
   input  logic signed [COORD_BITS-1:0]     req_ay,
   input  logic signed [COORD_BITS-1:0]     req_az,
   input  logic [pmh_pkg::WGT_W-1:0]        req_aw,
   input  logic signed [COORD_BITS-1:0]     req_bx,
   input  logic signed [COORD_BITS-1:0]     req_by,
   input  logic signed [COORD_BITS-1:0]     req_bz,
   input  logic [pmh_pkg::WGT_W-1:0]        req_bw,
   input  logic [pmh_pkg::ADDR_F_W-1:0]     req_bin_addr,
   input  logic                             req_last_pair,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pmh_pkg::BIN_W-1:0]        rsp_bin_value,
   output logic                             rsp_batch_done,
   input  logic                             csr_we,
   input  logic [pmh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pmh_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pmh_pkg::*;

   localparam int DW    = COORD_BITS + 1;
   localparam int SW    = 2 * COORD_BITS + 2;
   localparam int NW    = SW + 1;
   localparam int PW    = 2 * SW;
   localparam int XW    = SW + 2 * RCP_W;
   localparam int QW    = SW + FRAC_W;
   localparam int SBW   = (SEP_BINS > 1) ? $clog2(SEP_BINS) : 1;
   localparam int MBW   = $clog2(MU_BINS_MAX + 1);
   localparam int MBCW  = (MBW > MUB_W) ? MBW : MUB_W;
   localparam int DEPTH = SEP_BINS * MU_BINS_MAX;
   localparam int HAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int AFW   = (HAW + 1 > ADDR_F_W) ? HAW + 1 : ADDR_F_W;
   localparam int CNW   = $clog2(SW + 1);
   localparam int CMW   = (SW > LIM_W) ? SW : LIM_W;
   localparam int MPW   = MUQ_W + RCP_W;
   localparam int IMW   = MPW - MU_SHIFT;
   localparam int MCW   = (IMW > MBW) ? IMW : MBW;
   localparam int AMW   = SBW + MBW + 1;

   // configuration registers
   logic [MUB_W-1:0] mu_bins_ff;
   logic [LIM_W-1:0] max_sep_ff;
   logic [RCP_W-1:0] inv_mu_ff;
   logic [RCP_W-1:0] inv_sep_ff;
   logic [WGT_W-1:0] wgt_scale_ff;

   state_type state_ff, state_in;

   logic signed [COORD_BITS-1:0] pa [3];
   logic signed [COORD_BITS-1:0] pb [3];
   logic signed [DW-1:0]         dv [3];
   logic signed [DW-1:0]         lv [3];
   logic [DW-1:0]                dmag [3];
   logic [DW-1:0]                lmag [3];
   logic signed [DW:0]           ldv [3];

   logic [DW-1:0]        dm_ff [3];
   logic [DW-1:0]        lm_ff [3];
   logic signed [DW:0]   ld_ff [3];
   logic [DW-1:0]        dsh_ff [3];
   logic [DW-1:0]        lsh_ff [3];
   logic [SW-1:0]        s2_ff, s2_in;
   logic [SW-1:0]        l2_ff, l2_in;
   logic signed [NW-1:0] n_ff, n_in;
   logic [CNW-1:0]       cnt_ff;
   logic [SW-1:0]        an_ff;
   logic [2*RCP_W-1:0]   k2_ff;
   logic [SW-1:0]        ssh_ff;
   logic [PW-1:0]        p_ff, p_in;
   logic [XW-1:0]        x_ff;
   logic [SBW-1:0]       is_ff;
   logic [SBW-1:0]       sbit_ff;
   logic [SW-1:0]        r_ff;
   logic [QW-1:0]        rem_ff;
   logic [QW-1:0]        dvs_ff;
   logic [MUQ_W-1:0]     muq_ff;
   logic [MBW-1:0]       imu_ff;
   logic [2*WGT_W-1:0]   w1_ff;
   logic [BIN_W-1:0]     w_ff;
   logic [WGT_W-1:0]     aw_ff;
   logic [WGT_W-1:0]     bw_ff;
   logic                 last_ff;
   func_type             op_ff;
   logic                 inr_ff;
   logic [HAW-1:0]       addr_ff;
   logic [BIN_W-1:0]     rd_ff;
   logic [HAW-1:0]       clr_ff;

   logic                 rsp_valid_ff;
   logic [BIN_W-1:0]     rsp_value_ff;
   logic                 rsp_done_ff;

   logic [BIN_W-1:0]     hist_mem [DEPTH];

   logic                 accept;
   logic                 skip;
   logic                 need_rsp;
   logic                 out_free;
   logic                 rsp_load;
   logic                 sq_start;
   logic                 sq_done;
   logic [SW-1:0]        sq_root;
   logic [SBW-1:0]       scand;
   logic [2*SBW-1:0]     csq;
   logic                 sep_ok;
   logic                 div_ge;
   logic [MUQ_W-1:0]     muc;
   logic [MPW-1:0]       mprod;
   logic [MCW-1:0]       mhi;
   logic [MCW-1:0]       mlim;
   logic [MBCW-1:0]      mbw;
   logic [MBW-1:0]       mb_val;
   logic [AMW-1:0]       addr_sum;
   logic [BIN_W:0]       sum_w;
   logic                 mem_we;
   logic [HAW-1:0]       mem_wa;
   logic [BIN_W-1:0]     mem_wd;
   logic                 inr_req;

   assign pa[0] = req_ax;
   assign pa[1] = req_ay;
   assign pa[2] = req_az;
   assign pb[0] = req_bx;
   assign pb[1] = req_by;
   assign pb[2] = req_bz;

   // separation, doubled midpoint and their magnitudes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv[i]   = DW'(pa[i]) - DW'(pb[i]);
         lv[i]   = DW'(pa[i]) + DW'(pb[i]);
         dmag[i] = dv[i][DW-1] ? DW'(-dv[i]) : DW'(dv[i]);
         lmag[i] = lv[i][DW-1] ? DW'(-lv[i]) : DW'(lv[i]);
         ldv[i]  = dv[i][DW-1] ? -((DW+1)'(lv[i])) : (DW+1)'(lv[i]);
      end
   end

   // msb-first serial square sums and dot product
   always_comb begin
      s2_in = s2_ff << 1;
      l2_in = l2_ff << 1;
      n_in  = n_ff <<< 1;
      for (int i = 0; i < 3; i++) begin
         if (dsh_ff[i][DW-1]) begin
            s2_in = s2_in + SW'(dm_ff[i]);
            n_in  = n_in + NW'(ld_ff[i]);
         end
         if (lsh_ff[i][DW-1]) begin
            l2_in = l2_in + SW'(lm_ff[i]);
         end
      end
   end

   // next step of the serial s2*L2 product, also fed to the square root
   always_comb begin
      p_in = (p_ff << 1) + (ssh_ff[SW-1] ? PW'(l2_ff) : PW'(0));
   end

   // effective mu bin count
   always_comb begin
      mbw = MBCW'(mu_bins_ff);
      if (mu_bins_ff == '0) begin
         mb_val = MBW'(1);
      end else if (mbw > MBCW'(MU_BINS_MAX)) begin
         mb_val = MBW'(MU_BINS_MAX);
      end else begin
         mb_val = MBW'(mbw);
      end
   end

   // separation bin search, mu divider step, mu bin, address, saturating add, skip test, range check
   always_comb begin
      scand    = is_ff | sbit_ff;
      csq      = scand * scand;
      sep_ok   = (scand <= SBW'(SEP_BINS - 1)) &&
                 (XW'({csq, {(2*FRAC_W){1'b0}}}) <= x_ff);
      div_ge   = rem_ff >= dvs_ff;
      muc      = (muq_ff > MU_ONE) ? MU_ONE : muq_ff;
      mprod    = muc * inv_mu_ff;
      mhi      = MCW'(mprod[MPW-1:MU_SHIFT]);
      mlim     = MCW'(mb_val) - MCW'(1);
      addr_sum = AMW'(is_ff) * AMW'(mb_val) + AMW'(imu_ff);
      sum_w    = {1'b0, rd_ff} + {1'b0, w_ff};
      skip     = CMW'(s2_ff) >= CMW'(max_sep_ff);
      inr_req  = AFW'(req_bin_addr) < AFW'(DEPTH);
   end

   assign need_rsp = ((op_ff == FUNC_ADD) && last_ff) || (op_ff == FUNC_READ);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and control
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      sq_start  = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = addr_ff;
      mem_wd    = sum_w[BIN_W] ? BIN_MAX : sum_w[BIN_W-1:0];
      rsp_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            if (clr_ff == HAW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (func_type'(req_func))
                  FUNC_ADD:   state_in = ST_SQ;
                  FUNC_READ:  state_in = ST_MRD;
                  FUNC_CLEAR: state_in = ST_MUSE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SQ: begin
            if (cnt_ff == CNW'(1)) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            state_in = skip ? ST_DONE : ST_MUL;
         end
         ST_MUL: begin
            if (cnt_ff == CNW'(1)) begin
               sq_start = 1'b1;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sq_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (r_ff == '0 || cnt_ff == CNW'(1)) begin
               state_in = ST_MU;
            end
         end
         ST_MU:  state_in = ST_ADR;
         ST_ADR: state_in = ST_MRD;
         ST_MRD: state_in = (op_ff == FUNC_READ) ? ST_DONE : ST_MUSE;
         ST_MUSE: begin
            mem_we   = (op_ff == FUNC_ADD) || inr_ff;
            if (op_ff == FUNC_CLEAR) begin
               mem_wd = '0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!need_rsp) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mu_bins_ff   <= RST_MU_BINS;
         max_sep_ff   <= RST_MAX_SEP_SQ;
         inv_mu_ff    <= RST_INV_MU_W;
         inv_sep_ff   <= RST_INV_SEP_W;
         wgt_scale_ff <= RST_WGT_SCALE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MU_BINS:    mu_bins_ff   <= csr_wdata[MUB_W-1:0];
            CSR_MAX_SEP_SQ: max_sep_ff   <= csr_wdata[LIM_W-1:0];
            CSR_INV_MU_W:   inv_mu_ff    <= csr_wdata[RCP_W-1:0];
            CSR_INV_SEP_W:  inv_sep_ff   <= csr_wdata[RCP_W-1:0];
            CSR_WGT_SCALE:  wgt_scale_ff <= csr_wdata[WGT_W-1:0];
            default: ;
         endcase
      end
   end

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (state_ff == ST_CLEAR) begin
         clr_ff <= clr_ff + HAW'(1);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= func_type'(req_func);
         last_ff <= req_last_pair;
         aw_ff   <= req_aw;
         bw_ff   <= req_bw;
         addr_ff <= HAW'(req_bin_addr);
         inr_ff  <= inr_req;
         for (int i = 0; i < 3; i++) begin
            dm_ff[i]  <= dmag[i];
            lm_ff[i]  <= lmag[i];
            ld_ff[i]  <= ldv[i];
            dsh_ff[i] <= dmag[i];
            lsh_ff[i] <= lmag[i];
         end
         s2_ff  <= '0;
         l2_ff  <= '0;
         n_ff   <= '0;
         cnt_ff <= CNW'(DW);
      end
      case (state_ff)
         ST_SQ: begin
            for (int i = 0; i < 3; i++) begin
               dsh_ff[i] <= dsh_ff[i] << 1;
               lsh_ff[i] <= lsh_ff[i] << 1;
            end
            s2_ff  <= s2_in;
            l2_ff  <= l2_in;
            n_ff   <= n_in;
            cnt_ff <= cnt_ff - CNW'(1);
         end
         ST_CHK: begin
            ssh_ff  <= s2_ff;
            p_ff    <= '0;
            x_ff    <= '0;
            k2_ff   <= inv_sep_ff * inv_sep_ff;
            an_ff   <= n_ff[NW-1] ? SW'(-n_ff) : SW'(n_ff);
            is_ff   <= '0;
            sbit_ff <= {1'b1, {(SBW-1){1'b0}}};
            cnt_ff  <= CNW'(SW);
         end
         ST_MUL: begin
            p_ff   <= p_in;
            x_ff   <= (x_ff << 1) + (ssh_ff[SW-1] ? XW'(k2_ff) : XW'(0));
            ssh_ff <= ssh_ff << 1;
            cnt_ff <= cnt_ff - CNW'(1);
         end
         ST_ROOT: begin
            if (sbit_ff != '0) begin
               if (sep_ok) begin
                  is_ff <= scand;
               end
               sbit_ff <= sbit_ff >> 1;
            end
            if (sq_done) begin
               r_ff   <= sq_root;
               rem_ff <= {an_ff, {FRAC_W{1'b0}}};
               dvs_ff <= {sq_root, {FRAC_W{1'b0}}};
               muq_ff <= '0;
               cnt_ff <= CNW'(MUQ_W);
            end
         end
         ST_DIV: begin
            if (div_ge) begin
               rem_ff <= rem_ff - dvs_ff;
            end
            muq_ff <= {muq_ff[MUQ_W-2:0], div_ge};
            dvs_ff <= dvs_ff >> 1;
            cnt_ff <= cnt_ff - CNW'(1);
         end
         ST_MU: begin
            imu_ff <= (mhi > mlim) ? MBW'(mlim) : MBW'(mhi);
            w1_ff  <= aw_ff * wgt_scale_ff;
         end
         ST_ADR: begin
            addr_ff <= HAW'(addr_sum);
            w_ff    <= BIN_W'(w1_ff) * BIN_W'(bw_ff);
         end
         default: ;
      endcase
   end

   // histogram store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_wa] <= mem_wd;
      end
      if (state_ff == ST_MRD) begin
         rd_ff <= hist_mem[addr_ff];
      end
   end

   pmh_isqrt #(
      .ROOT_W(SW)
   ) u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .radicand(p_in),
      .done    (sq_done),
      .root    (sq_root)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= ((op_ff == FUNC_READ) && inr_ff) ? rd_ff : '0;
         rsp_done_ff  <= (op_ff == FUNC_ADD);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_value  = rsp_value_ff;
   assign rsp_batch_done = rsp_done_ff;

   `PMH_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "result without finished transaction")
   `PMH_ASSERT_IMP(a_wr_in_range, mem_we, AFW'(mem_wa) < AFW'(DEPTH), "store write beyond depth")
   `PMH_ASSERT_IMP(a_imu_range, state_ff == ST_ADR, imu_ff < mb_val, "mu bin beyond bin count")
   `PMH_ASSERT_IMP(a_is_range, state_ff == ST_MU, is_ff <= SBW'(SEP_BINS - 1), "separation bin beyond range")
   `PMH_ASSERT_NXT(a_skip_pair, (state_ff == ST_CHK) && skip, state_ff == ST_DONE, "far pair not skipped")

endmodule
`default_nettype wire

@@ hdl/pmh_isqrt.sv @@
`default_nettype none
module pmh_isqrt #(
   parameter int ROOT_W = 50
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2*ROOT_W-1:0] radicand,
   output logic                done,
   output logic [ROOT_W-1:0]   root
);
   localparam int CNW = $clog2(ROOT_W + 1);

   logic [2*ROOT_W-1:0] rad_ff;
   logic [ROOT_W:0]     rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [CNW-1:0]      cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [ROOT_W+2:0]   rem2;
   logic [ROOT_W+2:0]   trial;
   logic [ROOT_W+2:0]   diff;
   logic                fits;

   // one root bit per cycle, two radicand bits shifted in
   always_comb begin
      rem2  = {rem_ff, rad_ff[2*ROOT_W-1 -: 2]};
      trial = {1'b0, root_ff, 2'b01};
      fits  = rem2 >= trial;
      diff  = rem2 - trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= CNW'(ROOT_W);
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= fits ? diff[ROOT_W:0] : rem2[ROOT_W:0];
         root_ff <= {root_ff[ROOT_W-2:0], fits};
         cnt_ff  <= cnt_ff - CNW'(1);
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

@@ bench/pair_separation_mu_histogram_unit_checker.sv @@
`timescale 1ns / 1ps
module pair_separation_mu_histogram_unit_checker
   import pmh_pkg::*;
#(
   parameter int SEP_BINS    = 64,
   parameter int MU_BINS_MAX = 64,
   parameter int COORD_BITS  = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [1:0]                  req_func,
   input  logic signed [COORD_BITS-1:0] req_ax,
   input  logic signed [COORD_BITS-1:0] req_ay,
   input  logic signed [COORD_BITS-1:0] req_az,
   input  logic [WGT_W-1:0]            req_aw,
   input  logic signed [COORD_BITS-1:0] req_bx,
   input  logic signed [COORD_BITS-1:0] req_by,
   input  logic signed [COORD_BITS-1:0] req_bz,
   input  logic [WGT_W-1:0]            req_bw,
   input  logic [ADDR_F_W-1:0]         req_bin_addr,
   input  logic                        req_last_pair,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [BIN_W-1:0]            rsp_bin_value,
   input  logic                        rsp_batch_done,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   output int                          mismatches,
   output int                          pending
);

   localparam int DEPTH = SEP_BINS * MU_BINS_MAX;

   typedef struct packed {
      logic [BIN_W-1:0] value;
      logic             done;
   } bin_reply_t;

   // shadow of the histogram store and the registers
   logic [BIN_W-1:0] bin_sums [DEPTH];
   logic [MUB_W-1:0] mu_bins_r;
   logic [LIM_W-1:0] sep_limit_r;
   logic [RCP_W-1:0] inv_mu_r;
   logic [RCP_W-1:0] inv_sep_r;
   logic [WGT_W-1:0] scale_r;
   bin_reply_t       replies_due [$];

   // floor of the square root of a 128-bit value
   function automatic logic [63:0] floor_sqrt(logic [127:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int k = 63; k >= 0; k--) begin
         c = r | (64'd1 << k);
         if ({64'd0, c} * {64'd0, c} <= x) r = c;
      end
      return r;
   endfunction

   function automatic int eff_mu_bins();
      int mb;
      mb = mu_bins_r;
      if (mb == 0) mb = 1;
      if (mb > MU_BINS_MAX) mb = MU_BINS_MAX;
      return mb;
   endfunction

   // accumulate one weighted pair into the shadow histogram
   task automatic accumulate_pair();
      logic signed [63:0] av [3];
      logic signed [63:0] bv [3];
      logic signed [63:0] d, l, s2, l2, n;
      logic [63:0]  sep_bin, root, an, muq, c, imu, w;
      logic [127:0] num;
      logic [BIN_W:0] sum;
      int mb, addr;
      av[0] = req_ax; av[1] = req_ay; av[2] = req_az;
      bv[0] = req_bx; bv[1] = req_by; bv[2] = req_bz;
      s2 = 0; l2 = 0; n = 0;
      for (int i = 0; i < 3; i++) begin
         d = av[i] - bv[i];
         l = av[i] + bv[i];
         s2 += d * d;
         l2 += l * l;
         n  += d * l;
      end
      if ($unsigned(s2) >= {13'd0, sep_limit_r}) return;
      // separation bin
      sep_bin = floor_sqrt(128'($unsigned(s2)) * 128'(inv_sep_r) * 128'(inv_sep_r)) >> FRAC_W;
      if (sep_bin > SEP_BINS - 1) sep_bin = SEP_BINS - 1;
      // |mu| in Q1.16, one bit at a time
      root = floor_sqrt(128'($unsigned(s2)) * 128'($unsigned(l2)));
      an   = (n < 0) ? $unsigned(-n) : $unsigned(n);
      muq  = '0;
      if (root != 0) begin
         num = 128'(an) << FRAC_W;
         for (int k = 16; k >= 0; k--) begin
            c = muq | (64'd1 << k);
            if (128'(c) * 128'(root) <= num) muq = c;
         end
         if (muq > 64'(MU_ONE)) muq = 64'(MU_ONE);
      end
      mb  = eff_mu_bins();
      imu = (muq * 64'(inv_mu_r)) >> MU_SHIFT;
      if (imu > mb - 1) imu = mb - 1;
      addr = int'(sep_bin) * mb + int'(imu);
      if (addr >= DEPTH) return;
      // saturating weighted sum
      w   = 64'(req_aw) * 64'(scale_r) * 64'(req_bw);
      sum = {1'b0, bin_sums[addr]} + w[BIN_W:0];
      bin_sums[addr] = (sum > {1'b0, BIN_MAX}) ? BIN_MAX : sum[BIN_W-1:0];
   endtask

   always @(posedge clock) begin
      bin_reply_t got, want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) bin_sums[i] = '0;
         mu_bins_r   = RST_MU_BINS;
         sep_limit_r = RST_MAX_SEP_SQ;
         inv_mu_r    = RST_INV_MU_W;
         inv_sep_r   = RST_INV_SEP_W;
         scale_r     = RST_WGT_SCALE;
         replies_due.delete();
         mismatches  = 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_MU_BINS:    mu_bins_r   = csr_wdata[MUB_W-1:0];
               CSR_MAX_SEP_SQ: sep_limit_r = csr_wdata[LIM_W-1:0];
               CSR_INV_MU_W:   inv_mu_r    = csr_wdata[RCP_W-1:0];
               CSR_INV_SEP_W:  inv_sep_r   = csr_wdata[RCP_W-1:0];
               CSR_WGT_SCALE:  scale_r     = csr_wdata[WGT_W-1:0];
               default: ;
            endcase
         end
         // compare an outgoing transaction with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            got.value = rsp_bin_value;
            got.done  = rsp_batch_done;
            if (replies_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t unexpected result value=%h done=%b", $time,
                           got.value, got.done);
            end else begin
               want = replies_due.pop_front();
               if (got.value !== want.value || got.done !== want.done) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t mismatch: value exp %h got %h, done exp %b got %b",
                              $time, want.value, got.value, want.done, got.done);
               end
            end
         end
         // predict from an incoming transaction
         if (req_valid && req_ready) begin
            case (req_func)
               FUNC_ADD: begin
                  accumulate_pair();
                  if (req_last_pair) begin
                     want.value = '0;
                     want.done  = 1'b1;
                     replies_due.push_back(want);
                  end
               end
               FUNC_READ: begin
                  want.value = (req_bin_addr < DEPTH) ? bin_sums[req_bin_addr] : '0;
                  want.done  = 1'b0;
                  replies_due.push_back(want);
               end
               FUNC_CLEAR: if (req_bin_addr < DEPTH) bin_sums[req_bin_addr] = '0;
               default: ;
            endcase
         end
      end
      pending <= replies_due.size();
   end

endmodule

@@ bench/pair_separation_mu_histogram_unit_tb.sv @@
`timescale 1ns / 1ps
module pair_separation_mu_histogram_unit_tb;
   import pmh_pkg::*;

   localparam int SEP_BINS    = 64;
   localparam int MU_BINS_MAX = 64;
   localparam int COORD_BITS  = 24;
   localparam int IDLE_LIMIT  = 20000;
   localparam int SETTLE      = 200;
   localparam int HOLD_CYCLES = 2500;
   localparam logic [1:0]           FUNC_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 3'd5;
   localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic [1:0] req_func;
   logic signed [COORD_BITS-1:0] req_ax, req_ay, req_az, req_bx, req_by, req_bz;
   logic [WGT_W-1:0] req_aw, req_bw;
   logic [ADDR_F_W-1:0] req_bin_addr;
   logic req_last_pair;
   logic [BIN_W-1:0] rsp_bin_value;
   logic rsp_batch_done;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int mismatches, pending;

   logic hold_req, hold_used;
   int   hold_cnt, stall_mode, idle_cycles;
   int   burst_left, adds_sent, reads_sent, clears_sent, results_seen;

   pair_separation_mu_histogram_unit #(
      .SEP_BINS(SEP_BINS), .MU_BINS_MAX(MU_BINS_MAX), .COORD_BITS(COORD_BITS)
   ) dut (.*);

   pair_separation_mu_histogram_unit_checker #(
      .SEP_BINS(SEP_BINS), .MU_BINS_MAX(MU_BINS_MAX), .COORD_BITS(COORD_BITS)
   ) checker_i (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // random field values at the field widths
   function automatic logic signed [COORD_BITS-1:0] rnd_coord();
      return COORD_BITS'($urandom);
   endfunction

   function automatic logic [WGT_W-1:0] rnd_wgt();
      return WGT_W'($urandom);
   endfunction

   function automatic logic [ADDR_F_W-1:0] rnd_addr();
      return ADDR_F_W'($urandom);
   endfunction

   function automatic logic rnd_bit();
      return 1'($urandom);
   endfunction

   // receiver: one long hold-off on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_cnt   <= 0;
         hold_used  <= 1'b0;
         stall_mode <= 0;
      end else if (hold_req && !hold_used) begin
         hold_used <= 1'b1;
         hold_cnt  <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("** pair_separation_mu_histogram_unit: FAILED **");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
      if (reset) results_seen <= 0;
      else if (rsp_valid && rsp_ready) results_seen <= results_seen + 1;
   end

   // offer one transaction; valid stays up only while the burst continues
   task automatic send(input logic [1:0] fn,
                       input logic signed [COORD_BITS-1:0] ax, ay, az,
                       input logic [WGT_W-1:0] aw,
                       input logic signed [COORD_BITS-1:0] bx, by, bz,
                       input logic [WGT_W-1:0] bw,
                       input logic [ADDR_F_W-1:0] addr, input logic last);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_func <= fn;
      req_ax <= ax; req_ay <= ay; req_az <= az; req_aw <= aw;
      req_bx <= bx; req_by <= by; req_bz <= bz; req_bw <= bw;
      req_bin_addr <= addr;
      req_last_pair <= last;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      if (burst_left == 0) req_valid <= 1'b0;
      case (fn)
         FUNC_ADD:   adds_sent++;
         FUNC_READ:  reads_sent++;
         FUNC_CLEAR: clears_sent++;
         default: ;
      endcase
   endtask

   task automatic read_bin(input int addr);
      send(FUNC_READ, rnd_coord(), rnd_coord(), rnd_coord(), rnd_wgt(), rnd_coord(),
           rnd_coord(), rnd_coord(), rnd_wgt(), ADDR_F_W'(addr), rnd_bit());
   endtask

   // sender pauses until every expected result has come and the block settles
   task automatic drain();
      if (burst_left != 0) begin
         req_valid <= 1'b0;
         burst_left = 0;
      end
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_regs(input logic [MUB_W-1:0] mb, input logic [LIM_W-1:0] lim,
                           input logic [RCP_W-1:0] imw, input logic [RCP_W-1:0] isw,
                           input logic [WGT_W-1:0] ws);
      logic [CSR_IDX_W-1:0] idx [6];
      logic [CSR_DATA_W-1:0] val [6];
      idx = '{CSR_MU_BINS, CSR_MAX_SEP_SQ, CSR_INV_MU_W, CSR_INV_SEP_W, CSR_WGT_SCALE,
              CSR_UNUSED};
      val = '{CSR_DATA_W'(mb), CSR_DATA_W'(lim), CSR_DATA_W'(imw), CSR_DATA_W'(isw),
              CSR_DATA_W'(ws), {CSR_DATA_W{1'b1}}};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // random batches of pairs, each closed by a last pair, then reads and at times a clear
   task automatic random_part(input int n_items, input int mb_eff);
      int sent, n_adds, spread, k;
      logic signed [COORD_BITS-1:0] a [3];
      logic signed [COORD_BITS-1:0] b [3];
      sent = 0;
      while (sent < n_items) begin
         n_adds = $urandom_range(1, 8);
         for (int p = 0; p < n_adds; p++) begin
            k = $urandom_range(0, 3);
            spread = (k == 0) ? 8 : (k == 1) ? 64 : (k == 2) ? 4096 : 0;
            for (int j = 0; j < 3; j++) begin
               if (spread == 0) begin
                  a[j] = rnd_coord();
                  b[j] = rnd_coord();
               end else begin
                  a[j] = COORD_BITS'($signed($urandom_range(0, 2 * 8000000)) - 8000000);
                  b[j] = a[j] +
                         COORD_BITS'($signed($urandom_range(0, 2 * spread)) - spread);
               end
            end
            send(FUNC_ADD, a[0], a[1], a[2], rnd_wgt(), b[0], b[1], b[2], rnd_wgt(),
                 rnd_addr(), p == n_adds - 1);
            sent++;
         end
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 7) == 0) read_bin($urandom_range(0, 4095));
            else read_bin($urandom_range(0, SEP_BINS * mb_eff - 1));
            sent++;
         end
         if ($urandom_range(0, 9) == 0) begin
            send(FUNC_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_wgt(),
                 rnd_coord(), rnd_coord(), rnd_coord(), rnd_wgt(),
                 ADDR_F_W'($urandom_range(0, SEP_BINS * mb_eff - 1)), rnd_bit());
            sent++;
         end
         if ($urandom_range(0, 15) == 0)
            send(FUNC_UNUSED, rnd_coord(), rnd_coord(), rnd_coord(), rnd_wgt(),
                 rnd_coord(), rnd_coord(), rnd_coord(), rnd_wgt(), rnd_addr(), 1'b1);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_func = FUNC_ADD; req_last_pair = 1'b0;
      req_ax = '0; req_ay = '0; req_az = '0; req_bx = '0; req_by = '0; req_bz = '0;
      req_aw = '0; req_bw = '0; req_bin_addr = '0;
      csr_we = 1'b0; csr_index = CSR_MU_BINS; csr_wdata = '0;
      hold_req = 1'b0;
      burst_left = 0; adds_sent = 0; reads_sent = 0; clears_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: zero-length, extreme coordinates, mu of zero and one, weights
      send(FUNC_ADD, 0, 0, 0, '1, 0, 0, 0, '1, 0, 1'b0);
      send(FUNC_ADD, CMAX, CMAX, CMAX, '1, CMAX, CMAX, CMAX, '1, 0, 1'b0);
      send(FUNC_ADD, CMAX, CMAX, CMAX, '1, CMIN, CMIN, CMIN, '1, '1, 1'b1);
      send(FUNC_ADD, 100, 0, 0, 16'h0100, -100, 0, 0, 16'h0100, 0, 1'b0);
      send(FUNC_ADD, 30, 0, 0, 16'h0200, 10, 0, 0, 16'h0300, 0, 1'b0);
      send(FUNC_ADD, 5, 20, 0, 16'h0080, 5, -20, 0, 16'h0100, 0, 1'b1);
      send(FUNC_ADD, 3, 4, 0, 16'h0000, 0, 0, 0, 16'hFFFF, 0, 1'b1);
      send(FUNC_UNUSED, CMIN, CMIN, CMIN, '1, CMAX, CMAX, CMAX, '1, '1, 1'b1);
      read_bin(0); read_bin(63); read_bin(40 * 64); read_bin(20 * 64 + 63);
      read_bin(4095); read_bin(5 * 64);
      send(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
      send(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, '1, 1'b0);
      read_bin(0); read_bin(4095);
      drain();

      // defaults written back explicitly
      set_regs(RST_MU_BINS, RST_MAX_SEP_SQ, RST_INV_MU_W, RST_INV_SEP_W, RST_WGT_SCALE);
      random_part(70, 64);
      drain();

      // eight mu bins, coarse separation; long receiver hold-off with reads queued
      set_regs(7'd8, RST_MAX_SEP_SQ, 24'h080000, 24'h000800, 16'h0100);
      hold_req <= 1'b1;
      repeat (20) read_bin($urandom_range(0, 511));
      random_part(70, 8);
      drain();

      // single mu bin, tight limit, widest separation and weight scale
      set_regs(7'd1, 51'd5000, 24'h000000, 24'hFFFFFF, 16'hFFFF);
      send(FUNC_ADD, 1, 0, 0, '1, 0, 0, 0, '1, 0, 1'b0);
      send(FUNC_ADD, 1, 0, 0, '1, 0, 0, 0, '1, 0, 1'b0);
      send(FUNC_ADD, 70, 10, 0, '1, 0, 0, 0, '1, 0, 1'b1);
      send(FUNC_ADD, 71, 0, 0, '1, 0, 0, 0, '1, 0, 1'b1);
      read_bin(63); read_bin(64);
      random_part(70, 1);
      drain();

      // mu_bins of zero and nothing below the limit
      set_regs(7'd0, '0, 24'hFFFFFF, 24'h010000, 16'h0100);
      random_part(50, 1);
      drain();

      // oversized mu_bins, large limit, fine mu, very coarse separation
      set_regs(7'd127, 51'd1 << 40, 24'hFFFFFF, 24'h000100, 16'h0001);
      random_part(70, 64);
      drain();

      // odd mu_bins and random limit and scale
      set_regs(7'd37, LIM_W'({$urandom, $urandom}), 24'h250000, 24'h004000,
               WGT_W'($urandom));
      random_part(90, 37);
      drain();

      $display("run covered %0d adds, %0d reads, %0d clears, %0d results checked",
               adds_sent, reads_sent, clears_sent, results_seen);
      $display("across six register settings incl. extremes and one long output stall");
      if (mismatches == 0)
         $display("** pair_separation_mu_histogram_unit: PASSED **");
      else
         $display("** pair_separation_mu_histogram_unit: FAILED **");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/pmh_pkg.sv
hdl/pmh_isqrt.sv
hdl/pair_separation_mu_histogram_unit.sv
bench/pair_separation_mu_histogram_unit_checker.sv
bench/pair_separation_mu_histogram_unit_tb.sv
